### rtl/core/tpf_pkg.sv
// Shared types, codes and constants of the typed particle force step unit.
package tpf_pkg;

	localparam int DEF_MAX_PARTICLES = 1024;
	localparam int DEF_TYPE_COUNT    = 10;

	localparam logic [30:0] RST_BOUND_X     = 31'd3276800;
	localparam logic [30:0] RST_BOUND_Y     = 31'd3276800;
	localparam logic [30:0] RST_FORCE_SCALE = 31'd655360;
	localparam logic [16:0] RST_DAMPING     = 17'd39322;

	localparam logic [63:0] EPS_Q32 = 64'd429496;
	localparam logic [40:0] DV_CAP  = 41'h100_0000_0000;

	localparam int DIV_NUM_W = 64;
	localparam int DIV_FRAC  = 16;

	typedef enum logic [2:0] {
		CMD_CLEAR = 3'd0,
		CMD_ADD   = 3'd1,
		CMD_SET   = 3'd2,
		CMD_STEP  = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		REG_BOUND_X     = 2'd0,
		REG_BOUND_Y     = 2'd1,
		REG_FORCE_SCALE = 2'd2,
		REG_DAMPING     = 2'd3
	} reg_idx_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_BAD_INDEX = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE, S_READ_W, S_GAIN, S_GAIN_W, S_LDI, S_LDI_W, S_LDJ, S_LDJ_W,
		S_DX2, S_DY2, S_RR, S_CMP, S_NX, S_DXS, S_DXW, S_NY, S_DYS, S_DYW,
		S_NEXTJ, S_P2LD, S_P2W, S_FL, S_FH, S_FC, S_DM, S_DE, S_MV, S_ME, S_WB
	} st_t;

	typedef struct packed {
		logic [2:0]         command;
		logic [3:0]         particle_type;
		logic [30:0]        start_x;
		logic [30:0]        start_y;
		logic [3:0]         type_a;
		logic [3:0]         type_b;
		logic signed [31:0] factor_value;
		logic [30:0]        radius_value;
		logic [16:0]        step_time;
		logic [9:0]         particle_index;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [30:0] out_x;
		logic [30:0] out_y;
		logic [3:0]  out_type;
		logic [10:0] particle_count;
	} rsp_t;

endpackage

### rtl/core/tpf_div.sv
// Restoring divider, one quotient bit per cycle: floor(num * 2^16 / den).
module tpf_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic        busy,
	output logic        done,
	output logic [63:0] quot
);
	import tpf_pkg::*;

	localparam int DW   = DIV_NUM_W + DIV_FRAC;
	localparam int CNTW = $clog2(DW + 1);

	logic [DW-1:0]        sh_q;
	logic [DIV_NUM_W:0]   rem_q;
	logic [DIV_NUM_W-1:0] den_q;
	logic [CNTW-1:0]      cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_NUM_W:0]   rem_sh;
	logic [DIV_NUM_W:0]   rem_sub;
	logic                 take;

	// trial subtract of the shifted remainder
	assign rem_sh  = {rem_q[DIV_NUM_W-1:0], sh_q[DW-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign take    = rem_sh >= {1'b0, den_q};

	// count the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift dividend out, quotient bits in
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= {num, {DIV_FRAC{1'b0}}};
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			sh_q  <= {sh_q[DW-2:0], take};
			rem_q <= take ? rem_sub : rem_sh;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = sh_q[DIV_NUM_W-1:0];

endmodule

### rtl/core/typed_particle_force_step_unit.sv
// Top level: particle store, interaction table, step sequencer and shared multiplier.
//
// Usage: commands arrive on req (valid/ready) as one word; each yields exactly one
// word on rsp (valid/ready). Configuration registers are written through cfg_we,
// cfg_idx and cfg_data while the unit is idle.
// The user keeps to that rule; the unit itself does not enforce it. Clear, add and
// set interaction load their response word on acceptance, a read after its
// registered store read. A step visits every ordered pair, divides only for pairs
// within their radius, then integrates each particle; the serial divider (one
// quotient bit per cycle, 80 bits) and the single 32x32 multiplier set its length.
// One command is in flight at a time: req_ready is low from acceptance until the
// response word has been taken, so a stalled receiver holds the unit.
// Reset empties the store, invalidates the whole interaction table and loads the
// configuration defaults. Particle storage keeps no reset value; entries beyond the
// count are never read.
module typed_particle_force_step_unit #(
	parameter int MAX_PARTICLES = tpf_pkg::DEF_MAX_PARTICLES,
	parameter int TYPE_COUNT    = tpf_pkg::DEF_TYPE_COUNT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  tpf_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output tpf_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_idx,
	input  logic [30:0]   cfg_data
);
	import tpf_pkg::*;

	localparam int AW  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int CW  = $clog2(MAX_PARTICLES + 1);
	localparam int TD  = TYPE_COUNT * TYPE_COUNT;
	localparam int TAW = (TD > 1) ? $clog2(TD) : 1;

	// ---------------- helpers ----------------
	function automatic logic [TAW-1:0] tidx(input logic [3:0] a, input logic [3:0] b);
		return TAW'(int'(a) * TYPE_COUNT + int'(b));
	endfunction

	function automatic logic [31:0] mag33(input logic signed [32:0] v);
		logic signed [32:0] n;
		n = -v;
		return v[32] ? n[31:0] : v[31:0];
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		logic signed [31:0] n;
		n = -v;
		return v[31] ? n : v;
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		logic signed [63:0] n;
		n = -v;
		return v[63] ? n : v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
		if (v > 43'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -43'sh0_8000_0000) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic signed [32:0] torus(input logic [30:0] from_p,
			input logic [30:0] to_p, input logic [30:0] bound);
		logic signed [32:0] off;
		logic signed [32:0] delta;
		logic signed [32:0] a;
		off   = $signed({2'b00, to_p}) - $signed({2'b00, from_p});
		a     = off[32] ? -off : off;
		delta = $signed({2'b00, bound}) - a;
		if (delta < a) begin
			if (off > 33'sd0) off = -delta;
			else if (off < 33'sd0) off = delta;
			else off = '0;
		end
		return off;
	endfunction

	function automatic logic [30:0] wrap(input logic signed [35:0] p, input logic [30:0] b);
		logic signed [35:0] t;
		logic signed [35:0] bs;
		bs = $signed({5'b0, b});
		t  = p;
		if (t > bs) t = t - bs;
		else if (t < 36'sd0) t = t + bs;
		if (t < 36'sd0) return '0;
		if (t > 36'sh0_7FFF_FFFF) return '1;
		return t[30:0];
	endfunction

	// (|a| * b) >> 16 with cap, from the low and high partial products
	function automatic logic [40:0] capmul(input logic [63:0] hi, input logic [63:0] lo);
		logic [48:0] s;
		if (hi >= 64'h100_0000) return DV_CAP;
		s = {9'b0, hi[23:0], 16'b0} + {1'b0, lo[63:16]};
		if (s > {8'b0, DV_CAP}) return DV_CAP;
		return s[40:0];
	endfunction

	// ---------------- state ----------------
	st_t st_q, st_d;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] i_q, j_q;
	logic          ax_q;
	logic [30:0]   bound_x_q, bound_y_q, fs_q;
	logic [16:0]   damp_q;
	logic [16:0]   dt_q;
	logic [31:0]   gain_q;
	logic [63:0]   prod_q;
	logic [30:0]   pix_q, piy_q;
	logic [3:0]    ti_q;
	logic signed [32:0] dx_q, dy_q;
	logic [63:0]   dist2_q;
	logic signed [63:0] fx_q, fy_q;
	logic signed [63:0] f_q [2];
	logic signed [31:0] v_q [2];
	logic [30:0]   p_q [2];
	logic [63:0]   lo_q;
	rsp_t          rsp_q, rsp_d;
	logic          rsp_valid_q;

	// particle store
	logic [30:0]        pos_x_mem [MAX_PARTICLES];
	logic [30:0]        pos_y_mem [MAX_PARTICLES];
	logic signed [31:0] vel_x_mem [MAX_PARTICLES];
	logic signed [31:0] vel_y_mem [MAX_PARTICLES];
	logic [3:0]         kind_mem  [MAX_PARTICLES];
	logic signed [63:0] frc_x_mem [MAX_PARTICLES];
	logic signed [63:0] frc_y_mem [MAX_PARTICLES];
	logic [30:0]        rd_px_q, rd_py_q;
	logic signed [31:0] rd_vx_q, rd_vy_q;
	logic [3:0]         rd_kind_q;
	logic signed [63:0] rd_fx_q, rd_fy_q;

	// interaction table
	logic signed [31:0] fac_mem [TD];
	logic [30:0]        rad_mem [TD];
	logic [TD-1:0]      tab_vld_q;
	logic signed [31:0] fac_rd_q;
	logic [30:0]        rad_rd_q;
	logic               hit_q;

	// control from the sequencer
	logic          acc;
	cmd_t          cmd;
	logic          full;
	logic          add_ok, set_ok, read_ok;
	logic [AW-1:0] mem_ra;
	logic          add_we, wb_we, frc_we, tab_we, tab_re, rsp_load;
	logic [TAW-1:0] tab_wa, tab_ra;
	logic [31:0]   mul_a, mul_b;
	logic          div_start, div_busy, div_done;
	logic [63:0]   div_quot;
	logic          i_last, j_last;
	logic signed [31:0] fac_eff;
	logic [30:0]   rad_eff;
	logic [63:0]   fmag;
	logic [31:0]   vmag;
	logic [30:0]   bnd_ax;
	logic signed [42:0] v_inc;
	logic [40:0]   inc_r;
	logic signed [34:0] v_damp;
	logic signed [35:0] p_mov;
	logic          pair_neg_x, pair_neg_y;

	assign acc     = req_valid && req_ready;
	assign cmd     = cmd_t'(req.command);
	assign full    = 32'(cnt_q) >= MAX_PARTICLES;
	assign add_ok  = !full;
	assign set_ok  = (int'(req.type_a) < TYPE_COUNT) && (int'(req.type_b) < TYPE_COUNT);
	assign read_ok = (32'(req.particle_index) < 32'(cnt_q))
		&& (32'(req.particle_index) < MAX_PARTICLES);
	assign i_last  = ((CW+1)'(i_q) + (CW+1)'(1)) == (CW+1)'(cnt_q);
	assign j_last  = ((CW+1)'(j_q) + (CW+1)'(1)) == (CW+1)'(cnt_q);
	assign fac_eff = hit_q ? fac_rd_q : 32'sd0;
	assign rad_eff = hit_q ? rad_rd_q : 31'd0;
	assign fmag    = mag64(f_q[ax_q]);
	assign vmag    = mag32(v_q[ax_q]);
	assign bnd_ax  = ax_q ? bound_y_q : bound_x_q;
	assign pair_neg_x = fac_eff[31] ^ dx_q[32];
	assign pair_neg_y = fac_eff[31] ^ dy_q[32];

	// integration arithmetic for the current axis
	always_comb begin
		inc_r  = capmul(prod_q, lo_q);
		v_inc  = f_q[ax_q][63] ? ({{11{v_q[ax_q][31]}}, v_q[ax_q]} - $signed({2'b0, inc_r}))
			: ({{11{v_q[ax_q][31]}}, v_q[ax_q]} + $signed({2'b0, inc_r}));
		v_damp = v_q[ax_q][31] ? -$signed({2'b0, prod_q[48:16]})
			: $signed({2'b0, prod_q[48:16]});
		p_mov  = $signed({5'b0, p_q[ax_q]}) + (v_q[ax_q][31] ? -$signed({3'b0, prod_q[48:16]})
			: $signed({3'b0, prod_q[48:16]}));
	end

	tpf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod_q),
		.den    (dist2_q),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: begin
				if (acc) begin
					if (cmd == CMD_STEP) st_d = S_GAIN;
					else if (cmd == CMD_READ && read_ok) st_d = S_READ_W;
				end
			end
			S_READ_W: st_d = S_IDLE;
			S_GAIN:   st_d = S_GAIN_W;
			S_GAIN_W: st_d = (cnt_q == '0) ? S_IDLE : S_LDI;
			S_LDI:    st_d = S_LDI_W;
			S_LDI_W:  st_d = S_LDJ;
			S_LDJ:    st_d = S_LDJ_W;
			S_LDJ_W:  st_d = S_DX2;
			S_DX2:    st_d = S_DY2;
			S_DY2:    st_d = S_RR;
			S_RR:     st_d = S_CMP;
			S_CMP: begin
				if (dist2_q > prod_q || dist2_q <= EPS_Q32) st_d = S_NEXTJ;
				else st_d = S_NX;
			end
			S_NX:     st_d = S_DXS;
			S_DXS:    st_d = S_DXW;
			S_DXW:    if (div_done) st_d = S_NY;
			S_NY:     st_d = S_DYS;
			S_DYS:    st_d = S_DYW;
			S_DYW:    if (div_done) st_d = S_NEXTJ;
			S_NEXTJ: begin
				if (!j_last) st_d = S_LDJ;
				else if (i_last) st_d = S_P2LD;
				else st_d = S_LDI;
			end
			S_P2LD:   st_d = S_P2W;
			S_P2W:    st_d = S_FL;
			S_FL:     st_d = S_FH;
			S_FH:     st_d = S_FC;
			S_FC:     st_d = S_DM;
			S_DM:     st_d = S_DE;
			S_DE:     st_d = S_MV;
			S_MV:     st_d = S_ME;
			S_ME:     st_d = ax_q ? S_WB : S_FL;
			S_WB:     st_d = i_last ? S_IDLE : S_P2LD;
			default:  st_d = S_IDLE;
		endcase
	end

	// sequencer outputs: memory ports, multiplier operands, response
	always_comb begin
		mem_ra    = i_q;
		add_we    = 1'b0;
		wb_we     = 1'b0;
		frc_we    = 1'b0;
		tab_we    = 1'b0;
		tab_re    = 1'b0;
		tab_wa    = tidx(req.type_a, req.type_b);
		tab_ra    = tidx(ti_q, rd_kind_q);
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		rsp_load  = 1'b0;
		rsp_d     = '0;
		rsp_d.particle_count = 11'(cnt_q);
		case (st_q)
			S_IDLE: begin
				if (acc) begin
					case (cmd)
						CMD_CLEAR: begin
							rsp_load = 1'b1;
							rsp_d.particle_count = '0;
						end
						CMD_ADD: begin
							add_we   = add_ok;
							rsp_load = 1'b1;
							if (add_ok) rsp_d.particle_count = 11'(cnt_q + CW'(1));
							else rsp_d.status = ST_FULL;
						end
						CMD_SET: begin
							tab_we   = set_ok;
							rsp_load = 1'b1;
						end
						CMD_STEP: ;
						CMD_READ: begin
							mem_ra = AW'(req.particle_index);
							if (!read_ok) begin
								rsp_load     = 1'b1;
								rsp_d.status = ST_BAD_INDEX;
							end
						end
						default: rsp_load = 1'b1;
					endcase
				end
			end
			S_READ_W: begin
				rsp_load       = 1'b1;
				rsp_d.out_x    = rd_px_q;
				rsp_d.out_y    = rd_py_q;
				rsp_d.out_type = rd_kind_q;
			end
			S_GAIN: begin
				mul_a = 32'(fs_q);
				mul_b = 32'(dt_q);
			end
			S_GAIN_W: rsp_load = (cnt_q == '0);
			S_LDI:    mem_ra = i_q;
			S_LDJ:    mem_ra = j_q;
			S_LDJ_W:  tab_re = 1'b1;
			S_DX2: begin
				mul_a = mag33(dx_q);
				mul_b = mag33(dx_q);
			end
			S_DY2: begin
				mul_a = mag33(dy_q);
				mul_b = mag33(dy_q);
			end
			S_RR: begin
				mul_a = 32'(rad_eff);
				mul_b = 32'(rad_eff);
			end
			S_NX: begin
				mul_a = mag32(fac_eff);
				mul_b = mag33(dx_q);
			end
			S_DXS:    div_start = 1'b1;
			S_NY: begin
				mul_a = mag32(fac_eff);
				mul_b = mag33(dy_q);
			end
			S_DYS:    div_start = 1'b1;
			S_NEXTJ:  frc_we = j_last;
			S_P2LD:   mem_ra = i_q;
			S_FL: begin
				mul_a = fmag[31:0];
				mul_b = gain_q;
			end
			S_FH: begin
				mul_a = fmag[63:32];
				mul_b = gain_q;
			end
			S_DM: begin
				mul_a = vmag;
				mul_b = 32'(damp_q);
			end
			S_MV: begin
				mul_a = vmag;
				mul_b = 32'(dt_q);
			end
			S_WB: begin
				wb_we    = 1'b1;
				rsp_load = i_last;
			end
			default: ;
		endcase
	end

	// control registers, counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			cnt_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			ax_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
			tab_vld_q   <= '0;
			bound_x_q   <= RST_BOUND_X;
			bound_y_q   <= RST_BOUND_Y;
			fs_q        <= RST_FORCE_SCALE;
			damp_q      <= RST_DAMPING;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				case (reg_idx_t'(cfg_idx))
					REG_BOUND_X:     bound_x_q <= cfg_data;
					REG_BOUND_Y:     bound_y_q <= cfg_data;
					REG_FORCE_SCALE: fs_q      <= cfg_data;
					REG_DAMPING:     damp_q    <= cfg_data[16:0];
					default: ;
				endcase
			end
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
			if (acc && cmd == CMD_CLEAR) begin
				cnt_q     <= '0;
				tab_vld_q <= '0;
			end
			if (add_we) cnt_q <= cnt_q + CW'(1);
			if (tab_we) tab_vld_q[tab_wa] <= 1'b1;
			case (st_q)
				S_GAIN_W: i_q <= '0;
				S_LDI_W:  j_q <= '0;
				S_NEXTJ: begin
					if (!j_last) j_q <= j_q + AW'(1);
					else if (i_last) i_q <= '0;
					else i_q <= i_q + AW'(1);
				end
				S_P2W:    ax_q <= 1'b0;
				S_ME:     ax_q <= 1'b1;
				S_WB:     i_q <= i_q + AW'(1);
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		if (acc) dt_q <= req.step_time;
		if (rsp_load) rsp_q <= rsp_d;
		case (st_q)
			S_GAIN_W: gain_q <= prod_q[47:16];
			S_LDI_W: begin
				pix_q <= rd_px_q;
				piy_q <= rd_py_q;
				ti_q  <= rd_kind_q;
				fx_q  <= '0;
				fy_q  <= '0;
			end
			S_LDJ_W: begin
				dx_q <= torus(pix_q, rd_px_q, bound_x_q);
				dy_q <= torus(piy_q, rd_py_q, bound_y_q);
			end
			S_DY2:    dist2_q <= prod_q;
			S_RR:     dist2_q <= dist2_q + prod_q;
			S_DXW:    if (div_done) fx_q <= pair_neg_x ? fx_q - $signed(div_quot)
					: fx_q + $signed(div_quot);
			S_DYW:    if (div_done) fy_q <= pair_neg_y ? fy_q - $signed(div_quot)
					: fy_q + $signed(div_quot);
			S_P2W: begin
				f_q[0] <= rd_fx_q;
				f_q[1] <= rd_fy_q;
				v_q[0] <= rd_vx_q;
				v_q[1] <= rd_vy_q;
				p_q[0] <= rd_px_q;
				p_q[1] <= rd_py_q;
			end
			S_FH:     lo_q <= prod_q;
			S_FC:     v_q[ax_q] <= sat32(v_inc);
			S_DE:     v_q[ax_q] <= sat32({{8{v_damp[34]}}, v_damp});
			S_ME:     p_q[ax_q] <= wrap(p_mov, bnd_ax);
			default: ;
		endcase
	end

	// particle store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (add_we) begin
			pos_x_mem[AW'(cnt_q)] <= req.start_x;
			pos_y_mem[AW'(cnt_q)] <= req.start_y;
			vel_x_mem[AW'(cnt_q)] <= '0;
			vel_y_mem[AW'(cnt_q)] <= '0;
			kind_mem[AW'(cnt_q)]  <= req.particle_type;
		end else if (wb_we) begin
			pos_x_mem[i_q] <= p_q[0];
			pos_y_mem[i_q] <= p_q[1];
			vel_x_mem[i_q] <= v_q[0];
			vel_y_mem[i_q] <= v_q[1];
		end
		rd_px_q   <= pos_x_mem[mem_ra];
		rd_py_q   <= pos_y_mem[mem_ra];
		rd_vx_q   <= vel_x_mem[mem_ra];
		rd_vy_q   <= vel_y_mem[mem_ra];
		rd_kind_q <= kind_mem[mem_ra];
	end

	// force sums per particle
	always_ff @(posedge clk) begin
		if (frc_we) begin
			frc_x_mem[i_q] <= fx_q;
			frc_y_mem[i_q] <= fy_q;
		end
		rd_fx_q <= frc_x_mem[mem_ra];
		rd_fy_q <= frc_y_mem[mem_ra];
	end

	// interaction table; an invalid entry reads as zero
	always_ff @(posedge clk) begin
		if (tab_we) begin
			fac_mem[tab_wa] <= req.factor_value;
			rad_mem[tab_wa] <= req.radius_value;
		end
		if (tab_re) begin
			fac_rd_q <= fac_mem[tab_ra];
			rad_rd_q <= rad_mem[tab_ra];
			hit_q    <= tab_vld_q[tab_ra] && (int'(ti_q) < TYPE_COUNT)
				&& (int'(rd_kind_q) < TYPE_COUNT);
		end
	end

	assign req_ready = (st_q == S_IDLE) && !rsp_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// one command in flight at a time
	a_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("second command accepted while one is in flight");

	// divider is started only when idle
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

	// a full status is only reported with a full store
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_FULL) |-> (32'(cnt_q) >= MAX_PARTICLES))
		else $error("store full reported below capacity");

endmodule

### test/typed_particle_force_step_unit_tb.sv
// Self-checking testbench of the typed particle force step unit.
module typed_particle_force_step_unit_tb;
	import tpf_pkg::*;

	localparam int NPART = 1024;
	localparam int NTYPE = 10;
	localparam longint CYCLE_LIMIT = 8_000_000;
	localparam int ADD_CAP = 12;
	localparam int LONG_HOLD = 400;
	localparam logic [2:0] CMD_RSVD_LO = 3'd5;
	localparam logic [2:0] CMD_RSVD_MID = 3'd6;
	localparam logic [2:0] CMD_RSVD_HI = 3'd7;

	typedef struct {
		req_t w;
		bit   lit;
		rsp_t want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_t        rsp;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = REG_BOUND_X;
	logic [30:0] cfg_data = '0;

	// particle store and table mirror
	logic [30:0] bnd_x = RST_BOUND_X;
	logic [30:0] bnd_y = RST_BOUND_Y;
	logic [30:0] fscale = RST_FORCE_SCALE;
	logic [16:0] damp = RST_DAMPING;
	int          pos_x [NPART];
	int          pos_y [NPART];
	int          vel_x [NPART];
	int          vel_y [NPART];
	logic [3:0]  kind [NPART];
	longint      acc_x [NPART];
	longint      acc_y [NPART];
	int          fac_tab [NTYPE*NTYPE];
	int unsigned rad_tab [NTYPE*NTYPE];
	int unsigned count = 0;

	rsp_t        resp_q [$];
	int          errors = 0;
	int          sent = 0;
	int          checked = 0;
	int          steps = 0;
	int          fulls = 0;
	bit          gaps_on = 1'b1;
	bit          hold_req = 1'b0;
	int          hold_left = 0;
	int          stall_left = 0;
	longint      cycles = 0;

	typed_particle_force_step_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL typed_particle_force_step_unit");
			$finish;
		end
	end

	function automatic longint unsigned mag(longint a);
		return (a < 0) ? longint'(-a) : a;
	endfunction

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// sign(a) * min(|a|*b >> 16, 2^40)
	function automatic longint mulq(longint a, longint unsigned b);
		logic [127:0] p;
		p = (128'(mag(a)) * 128'(b)) >> 16;
		if (p > 128'(DV_CAP)) p = 128'(DV_CAP);
		return (a < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic longint pair_force(longint f, longint d, longint unsigned dist2);
		logic [127:0] q;
		q = ((128'(mag(f)) * 128'(mag(d))) << 16) / 128'(dist2);
		return ((f < 0) != (d < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	// shortest offset on the torus
	function automatic longint torus(longint from, longint to, longint bound);
		longint off, a, delta;
		off = to - from;
		a = (off < 0) ? -off : off;
		delta = bound - a;
		if (delta < a) off = (off > 0) ? -delta : ((off < 0) ? delta : 0);
		return off;
	endfunction

	function automatic int wrapb(longint p, longint bound);
		if (p > bound) p -= bound;
		else if (p < 0) p += bound;
		if (p < 0) p = 0;
		if (p > 64'sd2147483647) p = 64'sd2147483647;
		return int'(p);
	endfunction

	// advance every particle by one time step
	function automatic void advance(logic [16:0] dt);
		longint unsigned gain, dist2, rad;
		longint fx, fy, dx, dy, vx, vy, f;
		gain = (longint'(fscale) * longint'(dt)) >> 16;
		for (int i = 0; i < count; i++) begin
			fx = 0;
			fy = 0;
			for (int j = 0; j < count; j++) begin
				f = 0;
				rad = 0;
				if (kind[i] < NTYPE && kind[j] < NTYPE) begin
					f = fac_tab[kind[i]*NTYPE + kind[j]];
					rad = rad_tab[kind[i]*NTYPE + kind[j]];
				end
				dx = torus(pos_x[i], pos_x[j], bnd_x);
				dy = torus(pos_y[i], pos_y[j], bnd_y);
				dist2 = mag(dx) * mag(dx) + mag(dy) * mag(dy);
				if (!(dist2 > rad * rad || dist2 <= EPS_Q32)) begin
					fx += pair_force(f, dx, dist2);
					fy += pair_force(f, dy, dist2);
				end
			end
			acc_x[i] = fx;
			acc_y[i] = fy;
		end
		for (int i = 0; i < count; i++) begin
			vx = sat32(longint'(vel_x[i]) + mulq(acc_x[i], gain));
			vy = sat32(longint'(vel_y[i]) + mulq(acc_y[i], gain));
			vx = sat32(mulq(vx, damp));
			vy = sat32(mulq(vy, damp));
			vel_x[i] = int'(vx);
			vel_y[i] = int'(vy);
			pos_x[i] = wrapb(longint'(pos_x[i]) + mulq(vx, dt), bnd_x);
			pos_y[i] = wrapb(longint'(pos_y[i]) + mulq(vy, dt), bnd_y);
		end
	endfunction

	// apply one command to the mirror and return its response word
	function automatic rsp_t predict(req_t w);
		rsp_t r;
		r = '0;
		case (w.command)
			CMD_CLEAR: begin
				count = 0;
				for (int k = 0; k < NTYPE*NTYPE; k++) begin
					fac_tab[k] = 0;
					rad_tab[k] = 0;
				end
			end
			CMD_ADD: begin
				if (count >= NPART) begin
					r.status = ST_FULL;
					fulls++;
				end else begin
					pos_x[count] = int'(w.start_x);
					pos_y[count] = int'(w.start_y);
					vel_x[count] = 0;
					vel_y[count] = 0;
					kind[count] = w.particle_type;
					count++;
				end
			end
			CMD_SET: begin
				if (w.type_a < NTYPE && w.type_b < NTYPE) begin
					fac_tab[w.type_a*NTYPE + w.type_b] = w.factor_value;
					rad_tab[w.type_a*NTYPE + w.type_b] = w.radius_value;
				end
			end
			CMD_STEP: begin
				advance(w.step_time);
				steps++;
			end
			CMD_READ: begin
				if (w.particle_index >= count) r.status = ST_BAD_INDEX;
				else begin
					r.out_x = 31'(pos_x[w.particle_index]);
					r.out_y = 31'(pos_y[w.particle_index]);
					r.out_type = kind[w.particle_index];
				end
			end
			default: ;
		endcase
		r.particle_count = 11'(count);
		return r;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (!gaps_on) return 0;
		r = $urandom_range(0, 9);
		if (r < 5) return 0;
		if (r < 9) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic req_t w_cmd(logic [2:0] c);
		req_t w;
		w = '0;
		w.command = c;
		return w;
	endfunction

	function automatic req_t w_add(logic [3:0] t, logic [30:0] x, logic [30:0] y);
		req_t w;
		w = w_cmd(CMD_ADD);
		w.particle_type = t;
		w.start_x = x;
		w.start_y = y;
		return w;
	endfunction

	function automatic req_t w_set(logic [3:0] a, logic [3:0] b, logic [31:0] f,
			logic [30:0] r);
		req_t w;
		w = w_cmd(CMD_SET);
		w.type_a = a;
		w.type_b = b;
		w.factor_value = f;
		w.radius_value = r;
		return w;
	endfunction

	function automatic req_t w_step(logic [16:0] dt);
		req_t w;
		w = w_cmd(CMD_STEP);
		w.step_time = dt;
		return w;
	endfunction

	function automatic req_t w_read(logic [9:0] idx);
		req_t w;
		w = w_cmd(CMD_READ);
		w.particle_index = idx;
		return w;
	endfunction

	function automatic rsp_t lit_rsp(logic [1:0] st, logic [10:0] n);
		rsp_t r;
		r = '0;
		r.status = st;
		r.particle_count = n;
		return r;
	endfunction

	function automatic logic [30:0] rand_pos(logic [30:0] bound);
		if ($urandom_range(0, 9) < 8) return 31'($urandom_range(0, bound));
		return 31'($urandom);
	endfunction

	// random command word: every field random, the used ones shaped
	function automatic req_t rand_word();
		req_t w;
		int r;
		w.command = 3'($urandom);
		w.particle_type = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9));
		w.start_x = rand_pos(bnd_x);
		w.start_y = rand_pos(bnd_y);
		w.type_a = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9));
		w.type_b = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9));
		w.factor_value = ($urandom_range(0, 9) < 7) ?
			32'(int'($urandom_range(0, 1310720)) - 655360) : 32'($urandom);
		w.radius_value = ($urandom_range(0, 9) < 7) ?
			31'($urandom_range(0, bnd_x)) : 31'($urandom);
		w.step_time = 17'($urandom_range(0, 65536));
		w.particle_index = ($urandom_range(0, 9) < 8) ?
			10'($urandom_range(0, count)) : 10'($urandom);
		r = $urandom_range(0, 99);
		if (r < 5) w.command = CMD_CLEAR;
		else if (r < 35) w.command = (count >= ADD_CAP) ? CMD_READ : CMD_ADD;
		else if (r < 55) w.command = CMD_SET;
		else if (r < 70) w.command = CMD_STEP;
		else if (r < 95) w.command = CMD_READ;
		else w.command = 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
		return w;
	endfunction

	// offer one word, hold it until taken, then log its response
	task automatic send_word(input req_t w, input bit use_lit, input rsp_t lit);
		int gap;
		rsp_t p;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		p = predict(w);
		resp_q.push_back(use_lit ? lit : p);
		sent++;
	endtask

	// drop valid and wait until every response is back
	task automatic drain();
		req_valid <= 1'b0;
		while (resp_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic wr_cfg(input reg_idx_t idx, input logic [30:0] v);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= v;
		@(posedge clk);
		case (idx)
			REG_BOUND_X: bnd_x = v;
			REG_BOUND_Y: bnd_y = v;
			REG_FORCE_SCALE: fscale = v;
			REG_DAMPING: damp = v[16:0];
		endcase
	endtask

	// check each response word against the oldest expectation
	always @(posedge clk) begin : rsp_mon
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (resp_q.size() == 0) begin
				$error("response word with nothing pending");
				errors++;
			end else begin
				want = resp_q.pop_front();
				checked++;
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					errors++;
				end
				if (rsp.out_x !== want.out_x) begin
					$error("out_x: expected %0d, got %0d", want.out_x, rsp.out_x);
					errors++;
				end
				if (rsp.out_y !== want.out_y) begin
					$error("out_y: expected %0d, got %0d", want.out_y, rsp.out_y);
					errors++;
				end
				if (rsp.out_type !== want.out_type) begin
					$error("out_type: expected %0d, got %0d", want.out_type, rsp.out_type);
					errors++;
				end
				if (rsp.particle_count !== want.particle_count) begin
					$error("particle_count: expected %0d, got %0d",
						want.particle_count, rsp.particle_count);
					errors++;
				end
			end
		end
		// receiver stalls: one long hold on request, else random gaps
		if (hold_req) begin
			hold_left = LONG_HOLD;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	initial begin
		dir_row_t dir_tab [$];
		rsp_t none;
		none = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty store, extremes, ignored entries, epsilon pair, odd type
		dir_tab.push_back('{w_read(0), 1'b1, lit_rsp(ST_BAD_INDEX, 0)});
		dir_tab.push_back('{w_step(17'd65536), 1'b1, lit_rsp(ST_OK, 0)});
		dir_tab.push_back('{w_cmd(CMD_RSVD_HI), 1'b1, lit_rsp(ST_OK, 0)});
		dir_tab.push_back('{w_set(0, 0, 32'h8000_0000, 31'd1310720), 1'b0, none});
		dir_tab.push_back('{w_set(0, 1, 32'h7FFF_FFFF, 31'h7FFF_FFFF), 1'b0, none});
		dir_tab.push_back('{w_set(10, 0, 32'd65536, 31'd65536), 1'b1, lit_rsp(ST_OK, 0)});
		dir_tab.push_back('{w_set(9, 15, 32'd65536, 31'd65536), 1'b1, lit_rsp(ST_OK, 0)});
		dir_tab.push_back('{w_add(0, 31'd655360, 31'd655360), 1'b1, lit_rsp(ST_OK, 1)});
		dir_tab.push_back('{w_add(1, 31'd786432, 31'd655360), 1'b0, none});
		dir_tab.push_back('{w_add(15, 31'd0, 31'd0), 1'b0, none});
		dir_tab.push_back('{w_add(9, 31'h7FFF_FFFF, 31'h7FFF_FFFF), 1'b0, none});
		dir_tab.push_back('{w_add(0, 31'd655426, 31'd655360), 1'b0, none});
		dir_tab.push_back('{w_set(1, 0, 32'd65536, 31'd1966080), 1'b0, none});
		dir_tab.push_back('{w_set(9, 9, 32'd327680, 31'h7FFF_FFFF), 1'b0, none});
		dir_tab.push_back('{w_step(17'd65536), 1'b0, none});
		dir_tab.push_back('{w_step(17'd0), 1'b0, none});
		dir_tab.push_back('{w_step(17'd1), 1'b0, none});
		for (int k = 0; k < 5; k++) dir_tab.push_back('{w_read(10'(k)), 1'b0, none});
		dir_tab.push_back('{w_read(10'd1023), 1'b1, lit_rsp(ST_BAD_INDEX, 5)});
		dir_tab.push_back('{w_cmd(CMD_CLEAR), 1'b1, lit_rsp(ST_OK, 0)});
		dir_tab.push_back('{w_cmd(CMD_RSVD_LO), 1'b1, lit_rsp(ST_OK, 0)});
		dir_tab.push_back('{w_cmd(CMD_RSVD_MID), 1'b1, lit_rsp(ST_OK, 0)});
		foreach (dir_tab[k]) send_word(dir_tab[k].w, dir_tab[k].lit, dir_tab[k].want);
		drain();

		// fill the store back to back, overflow once, then empty it
		gaps_on = 1'b0;
		for (int k = 0; k < NPART; k++) send_word(rand_word() & '0 | w_add(
			4'($urandom_range(0, 9)), rand_pos(bnd_x), rand_pos(bnd_y)), 1'b0, none);
		send_word(w_add(3, 31'd65536, 31'd65536), 1'b1, lit_rsp(ST_FULL, 11'd1024));
		send_word(w_read(10'd1023), 1'b0, none);
		send_word(w_cmd(CMD_CLEAR), 1'b1, lit_rsp(ST_OK, 0));
		drain();

		// random phases under different register settings
		for (int ph = 0; ph < 4; ph++) begin
			drain();
			case (ph)
				0: begin
					wr_cfg(REG_BOUND_X, 31'd65536);
					wr_cfg(REG_BOUND_Y, 31'h7FFF_FFFF);
					wr_cfg(REG_FORCE_SCALE, 31'h7FFF_FFFF);
					wr_cfg(REG_DAMPING, 31'd65536);
				end
				1: begin
					wr_cfg(REG_BOUND_X, RST_BOUND_X);
					wr_cfg(REG_BOUND_Y, RST_BOUND_Y);
					wr_cfg(REG_FORCE_SCALE, 31'd0);
					wr_cfg(REG_DAMPING, 31'd0);
				end
				2: begin
					wr_cfg(REG_BOUND_X, 31'($urandom_range(65536, 6553600)));
					wr_cfg(REG_BOUND_Y, 31'($urandom_range(65536, 6553600)));
					wr_cfg(REG_FORCE_SCALE, 31'($urandom_range(0, 2621440)));
					wr_cfg(REG_DAMPING, 31'($urandom_range(0, 65536)));
				end
				default: begin
					wr_cfg(REG_BOUND_X, RST_BOUND_X);
					wr_cfg(REG_BOUND_Y, RST_BOUND_Y);
					wr_cfg(REG_FORCE_SCALE, RST_FORCE_SCALE);
					wr_cfg(REG_DAMPING, RST_DAMPING);
				end
			endcase
			cfg_we <= 1'b0;
			@(posedge clk);
			gaps_on = (ph != 3);
			if (ph == 1) hold_req = 1'b1;
			for (int k = 0; k < 25; k++) begin
				if (ph == 2 && k == 12) drain();
				send_word(rand_word(), 1'b0, none);
			end
		end

		// wait out the last responses
		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d commands (%0d steps, %0d adds on a full store),", sent, steps,
			fulls);
		$display("%0d response words compared under five register settings", checked);
		if (errors == 0) begin
			$display("PASS typed_particle_force_step_unit");
		end else begin
			$display("FAIL typed_particle_force_step_unit");
		end
		$finish;
	end

endmodule

### typed_particle_force_step_unit.f
rtl/core/tpf_pkg.sv
rtl/core/tpf_div.sv
rtl/core/typed_particle_force_step_unit.sv
test/typed_particle_force_step_unit_tb.sv
